>>> sv/pscsa_pkg.sv
// Package for the projected sub-chain size accumulator.
// Holds field widths, register indexes, derived arithmetic widths and the
// command bundle that the controller sends to the datapath. No dependencies.
package pscsa_pkg;

  localparam int unsigned MAX_CHAIN_LEN = 1024;

  localparam int unsigned LEN_W   = 11;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned BOND_W  = 20;
  localparam int unsigned TOTAL_W = 63;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned CFG_W   = DIR_W;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z        = 2'd3;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd2;
  localparam logic [DIR_W-1:0] DIRX_RESET = 18'd0;
  localparam logic [DIR_W-1:0] DIRY_RESET = 18'd0;
  localparam logic [DIR_W-1:0] DIRZ_RESET = 18'd65536;

  localparam logic [LEN_W-1:0] LEN_MIN = 11'd2;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CHAIN_LEN);

  // Bond position and bond index width.
  localparam int unsigned POS_W = $clog2(MAX_CHAIN_LEN);

  // Projection arithmetic.
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned MAC_W  = BOND_W + DIR_W;
  localparam int unsigned ACC_W  = MAC_W + 2;
  localparam int unsigned P_W    = ACC_W - FRAC_W;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  // Prefix sums and the closed-form increment.
  localparam int unsigned NP_W   = 32;
  localparam int unsigned PSQ_W  = 2 * NP_W - 1;
  localparam int unsigned S1_W   = NP_W + POS_W;
  localparam int unsigned S2_W   = 64;
  localparam int unsigned HALF_W = S1_W / 2;
  localparam int unsigned KP_W   = PSQ_W + POS_W;
  localparam int unsigned A_W    = KP_W + 1;
  localparam int unsigned X_W    = NP_W + 2 * HALF_W;
  localparam int unsigned B_W    = X_W + 1;
  localparam int unsigned INC_W  = B_W + 1;
  localparam int unsigned SUM_W  = INC_W + 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    logic  load;
    logic  mac;
    axis_e axis;
    logic  rnd;
    logic  sq;
    logic  km;
    logic  xl;
    logic  xh;
    logic  add;
    logic  inc;
    logic  fin;
  } cmd_t;

endpackage

>>> sv/pscsa_ifs.sv
// Valid/ready channel interfaces for bond items and result items.
// Depends on pscsa_pkg for the field widths.
interface pscsa_bond_if import pscsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [BOND_W-1:0] bond_x;
  logic signed [BOND_W-1:0] bond_y;
  logic signed [BOND_W-1:0] bond_z;

  modport source (output valid, output bond_x, output bond_y, output bond_z, input ready);
  modport sink   (input valid, input bond_x, input bond_y, input bond_z, output ready);
endinterface

interface pscsa_result_if import pscsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_sum;
  logic [COUNT_W-1:0] chains_done;
  logic               chain_end;

  modport source (output valid, output total_sum, output chains_done, output chain_end,
                  input ready);
  modport sink   (input valid, input total_sum, input chains_done, input chain_end,
                  output ready);
endinterface

>>> sv/pscsa_ctrl.sv
// Sequencing controller for the accumulator: steps one bond through the
// datapath and owns the output valid flag. Depends on pscsa_pkg.
module pscsa_ctrl import pscsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_MZ   = 4'd3;
  localparam logic [3:0] S_NP   = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_KM   = 4'd6;
  localparam logic [3:0] S_XL   = 4'd7;
  localparam logic [3:0] S_XH   = 4'd8;
  localparam logic [3:0] S_AD   = 4'd9;
  localparam logic [3:0] S_IC   = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = AXIS_X;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MX;
        end
      end
      S_MX: begin
        cmd_o.mac  = 1'b1;
        cmd_o.axis = AXIS_X;
        state_d    = S_MY;
      end
      S_MY: begin
        cmd_o.mac  = 1'b1;
        cmd_o.axis = AXIS_Y;
        state_d    = S_MZ;
      end
      S_MZ: begin
        cmd_o.mac  = 1'b1;
        cmd_o.axis = AXIS_Z;
        state_d    = S_NP;
      end
      S_NP: begin
        cmd_o.rnd = 1'b1;
        state_d   = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_KM;
      end
      S_KM: begin
        cmd_o.km = 1'b1;
        state_d  = S_XL;
      end
      S_XL: begin
        cmd_o.xl = 1'b1;
        state_d  = S_XH;
      end
      S_XH: begin
        cmd_o.xh = 1'b1;
        state_d  = S_AD;
      end
      S_AD: begin
        cmd_o.add = 1'b1;
        state_d   = S_IC;
      end
      S_IC: begin
        cmd_o.inc = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MX))
    else $error("accepted bond did not start the projection");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN && out_valid_q))
    else $error("result finished while the output slot was occupied");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("output valid rose outside the final step");

endmodule

>>> sv/pscsa_datapath.sv
// Datapath of the accumulator: configuration registers, projection MAC,
// prefix sums, closed-form increment and the saturating total.
// Depends on pscsa_pkg; driven by pscsa_ctrl through cmd_t.
module pscsa_datapath import pscsa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  cmd_t                     cmd_i,
  input  logic signed [BOND_W-1:0] bond_x_i,
  input  logic signed [BOND_W-1:0] bond_y_i,
  input  logic signed [BOND_W-1:0] bond_z_i,
  output logic [TOTAL_W-1:0]       total_sum_o,
  output logic [COUNT_W-1:0]       chains_done_o,
  output logic                     chain_end_o
);

  // Configuration.
  logic [LEN_W-1:0] len_q;
  logic [DIR_W-1:0] dx_q, dy_q, dz_q;

  // Per-item working registers.
  logic [BOND_W-1:0] bx_q, by_q, bz_q;
  logic [ACC_W-1:0]  acc_q;
  logic [NP_W-1:0]   np_q;
  logic [NP_W-1:0]   mag_np_q;
  logic [S1_W-1:0]   s1m_q;
  logic [PSQ_W-1:0]  psq_q;
  logic [KP_W-1:0]   kp_q;
  logic [X_W-1:0]    x_q;
  logic [A_W-1:0]    a_q;
  logic [INC_W-1:0]  inc_q;

  // Chain state.
  logic [NP_W-1:0]    prefix_q;
  logic [S1_W-1:0]    s1_q;
  logic [S2_W-1:0]    s2_q;
  logic [POS_W-1:0]   pos_q;
  logic [TOTAL_W-1:0] rt_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               end_q;

  logic [BOND_W-1:0]       mac_a;
  logic [DIR_W-1:0]        mac_b;
  logic signed [MAC_W-1:0] mac_prod;
  logic [ACC_W-1:0]        mac_ext;
  logic [ACC_W-1:0]        rnd;
  logic [P_W-1:0]          p;
  logic [NP_W:0]           np_wide;
  logic [NP_W-1:0]         np_sat;
  logic [S1_W-1:0]         s1_mag;
  logic [NP_W-1:0]         mag_np;
  logic [2*NP_W-1:0]       sq_full;
  logic [POS_W-1:0]        k;
  logic [KP_W-1:0]         kp_full;
  logic [HALF_W-1:0]       xmul_b;
  logic [NP_W+HALF_W-1:0]  xp_full;
  logic                    opp;
  logic [INC_W-1:0]        a_ext, b_ext, inc_d;
  logic [SUM_W-1:0]        tsum;
  logic [TOTAL_W-1:0]      rt_d;
  logic [LEN_W-1:0]        len_eff, bonds_full;
  logic [POS_W-1:0]        bonds;
  logic                    chain_end;
  logic [S2_W:0]           s2_sum;
  logic [S2_W-1:0]         s2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
      dx_q  <= DIRX_RESET;
      dy_q  <= DIRY_RESET;
      dz_q  <= DIRZ_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHAIN_LENGTH: len_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_DIR_X:        dx_q  <= cfg_wdata_i[DIR_W-1:0];
        CFG_DIR_Y:        dy_q  <= cfg_wdata_i[DIR_W-1:0];
        CFG_DIR_Z:        dz_q  <= cfg_wdata_i[DIR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Projection: one 20x18 product per step, accumulated in acc_q.
  always_comb begin
    case (cmd_i.axis)
      AXIS_X: begin
        mac_a = bx_q;
        mac_b = dx_q;
      end
      AXIS_Y: begin
        mac_a = by_q;
        mac_b = dy_q;
      end
      AXIS_Z: begin
        mac_a = bz_q;
        mac_b = dz_q;
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  assign mac_prod = $signed(mac_a) * $signed(mac_b);
  assign mac_ext  = {{(ACC_W-MAC_W){mac_prod[MAC_W-1]}}, mac_prod};

  // Round to nearest, ties up, then add to the saturating prefix.
  assign rnd     = acc_q + ROUND_HALF;
  assign p       = rnd[ACC_W-1:FRAC_W];
  assign np_wide = {prefix_q[NP_W-1], prefix_q} + {{(NP_W+1-P_W){p[P_W-1]}}, p};

  always_comb begin
    if (np_wide[NP_W] != np_wide[NP_W-1]) begin
      np_sat = np_wide[NP_W] ? {1'b1, {(NP_W-1){1'b0}}} : {1'b0, {(NP_W-1){1'b1}}};
    end else begin
      np_sat = np_wide[NP_W-1:0];
    end
  end

  assign s1_mag = s1_q[S1_W-1] ? (~s1_q + 1'b1) : s1_q;
  assign mag_np = np_q[NP_W-1] ? (~np_q + 1'b1) : np_q;
  assign sq_full = mag_np * mag_np;

  assign k       = pos_q + 1'b1;
  assign kp_full = k * psq_q;

  // |P| * |S1| in two halves of S1 on one multiplier.
  assign xmul_b  = cmd_i.xh ? s1m_q[S1_W-1:HALF_W] : s1m_q[HALF_W-1:0];
  assign xp_full = mag_np_q * xmul_b;

  assign opp   = (np_q[NP_W-1] != s1_q[S1_W-1]) && (|np_q) && (|s1_q);
  assign a_ext = INC_W'(a_q);
  assign b_ext = INC_W'({x_q, 1'b0});

  always_comb begin
    if (opp) begin
      inc_d = a_ext + b_ext;
    end else if (a_ext >= b_ext) begin
      inc_d = a_ext - b_ext;
    end else begin
      inc_d = '0;
    end
  end

  assign tsum = SUM_W'(rt_q) + SUM_W'(inc_q);
  assign rt_d = (tsum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : tsum[TOTAL_W-1:0];

  always_comb begin
    if (len_q < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (len_q > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_q;
    end
  end

  assign bonds_full = len_eff - 1'b1;
  assign bonds      = bonds_full[POS_W-1:0];
  assign chain_end  = (k >= bonds);

  assign s2_sum = {1'b0, s2_q} + (S2_W+1)'(psq_q);
  assign s2_d   = s2_sum[S2_W] ? {S2_W{1'b1}} : s2_sum[S2_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bx_q  <= bond_x_i;
      by_q  <= bond_y_i;
      bz_q  <= bond_z_i;
      acc_q <= '0;
    end else if (cmd_i.mac) begin
      acc_q <= acc_q + mac_ext;
    end
    if (cmd_i.rnd) begin
      np_q  <= np_sat;
      s1m_q <= s1_mag;
    end
    if (cmd_i.sq) begin
      mag_np_q <= mag_np;
      psq_q    <= sq_full[PSQ_W-1:0];
    end
    if (cmd_i.km) begin
      kp_q <= kp_full;
    end
    if (cmd_i.xl) begin
      x_q <= {{HALF_W{1'b0}}, xp_full};
    end else if (cmd_i.xh) begin
      x_q <= x_q + {xp_full, {HALF_W{1'b0}}};
    end
    if (cmd_i.add) begin
      a_q <= A_W'(kp_q) + A_W'(s2_q);
    end
    if (cmd_i.inc) begin
      inc_q <= inc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      s1_q     <= '0;
      s2_q     <= '0;
      pos_q    <= '0;
      rt_q     <= '0;
      cnt_q    <= '0;
      end_q    <= 1'b0;
    end else if (cmd_i.fin) begin
      rt_q  <= rt_d;
      end_q <= chain_end;
      if (chain_end) begin
        prefix_q <= '0;
        s1_q     <= '0;
        s2_q     <= '0;
        pos_q    <= '0;
        if (cnt_q != COUNT_MAX) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else begin
        prefix_q <= np_q;
        s1_q     <= s1_q + {{(S1_W-NP_W){np_q[NP_W-1]}}, np_q};
        s2_q     <= s2_d;
        pos_q    <= k;
      end
    end
  end

  assign total_sum_o   = rt_q;
  assign chains_done_o = cnt_q;
  assign chain_end_o   = end_q;

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && chain_end) |=> (pos_q == '0 && s1_q == '0 && prefix_q == '0))
    else $error("chain state not cleared at chain end");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(MAX_CHAIN_LEN - 1))
    else $error("bond position past the longest chain");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin && cnt_q == COUNT_MAX) |=> (cnt_q == COUNT_MAX))
    else $error("chain count wrapped");

endmodule

>>> sv/projected_subchain_size_accumulator_unit.sv
// Top level of the projected sub-chain size accumulator.
// Depends on pscsa_pkg, pscsa_ifs, pscsa_ctrl and pscsa_datapath.
//
// Bond vectors enter on bond_i (valid/ready), chain after chain, with
// chain_length - 1 bonds per chain. Each bond is projected on the director,
// added to the running prefix, and the squared projections of all sub-chains
// ending at that bond are added to a saturating total. Every bond gives one
// result on result_o: the total, the count of finished chains and a flag that
// marks the bond that closed a chain.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i (index 0
// chain_length, 1 to 3 the director x, y and z); the user must write them only
// while the block is idle, which the block does not enforce. Each bond walks
// a sequence on one shared datapath: three projection MAC steps, rounding,
// square, position multiply, two cross-term multiply halves, two wide add steps
// and the final update, which sets the result valid; no bond is taken before it.
// A result waiting at the output does not block the next bond; that bond
// holds in its final step until the waiting result has been transferred.
// Reset clears the chain state, the total, the count and restores the
// register defaults (length 2, director along z).
module projected_subchain_size_accumulator_unit import pscsa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  pscsa_bond_if.sink           bond_i,
  pscsa_result_if.source       result_o
);

  cmd_t cmd;

  pscsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bond_i.valid),
    .in_ready_o  (bond_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  pscsa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .bond_x_i      (bond_i.bond_x),
    .bond_y_i      (bond_i.bond_y),
    .bond_z_i      (bond_i.bond_z),
    .total_sum_o   (result_o.total_sum),
    .chains_done_o (result_o.chains_done),
    .chain_end_o   (result_o.chain_end)
  );

endmodule

>>> verif/projected_subchain_size_accumulator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for projected_subchain_size_accumulator_unit.
// Predicts every result from its own model of the bond projection and prefix sums,
// and depends on pscsa_pkg, the channel interfaces in pscsa_ifs and the block RTL.
module projected_subchain_size_accumulator_unit_test import pscsa_pkg::*; ();

  typedef struct packed {
    logic [TOTAL_W-1:0] total_sum;
    logic [COUNT_W-1:0] chains_done;
    logic               chain_end;
  } chain_result_t;

  localparam logic signed [BOND_W-1:0] BOND_HI = {1'b0, {(BOND_W-1){1'b1}}};
  localparam logic signed [BOND_W-1:0] BOND_LO = {1'b1, {(BOND_W-1){1'b0}}};
  localparam logic [CFG_W-1:0] DIR_ONE     = CFG_W'(65536);
  localparam logic [CFG_W-1:0] DIR_NEG_ONE = CFG_W'(-65536);
  localparam logic [CFG_W-1:0] DIR_HALF    = CFG_W'(32768);

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]  cfg_wdata;

  pscsa_bond_if   bond_ch ();
  pscsa_result_if result_ch ();

  projected_subchain_size_accumulator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .bond_i      (bond_ch),
    .result_o    (result_ch)
  );

  // Register copies and chain state of the predictor.
  logic [LEN_W-1:0]         len_q     = LEN_RESET;
  logic signed [DIR_W-1:0]  dir_x_q   = DIRX_RESET;
  logic signed [DIR_W-1:0]  dir_y_q   = DIRY_RESET;
  logic signed [DIR_W-1:0]  dir_z_q   = DIRZ_RESET;
  logic signed [NP_W-1:0]   prefix_q  = '0;
  logic signed [S1_W-1:0]   prefix_sum_q = '0;
  logic [S2_W-1:0]          prefix_sq_sum_q = '0;
  logic [POS_W-1:0]         bond_pos_q = '0;
  logic [TOTAL_W-1:0]       total_q   = '0;
  logic [COUNT_W-1:0]       count_q   = '0;

  chain_result_t predicted_results[$];
  int mismatch_count = 0;
  int tx_idle_pct = 11;
  int rx_idle_pct = 60;

  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic chain_result_t accumulate_bond(input logic signed [BOND_W-1:0] bx,
                                                    input logic signed [BOND_W-1:0] by,
                                                    input logic signed [BOND_W-1:0] bz);
    longint        dot;
    longint        np;
    logic [63:0]   np_mag;
    logic [63:0]   psq;
    logic [127:0]  a_term;
    logic [127:0]  b_term;
    logic [127:0]  inc;
    int unsigned   k;
    int unsigned   eff_len;
    logic          closes_chain;
    chain_result_t r;
    dot = longint'(bx) * longint'(dir_x_q) + longint'(by) * longint'(dir_y_q)
        + longint'(bz) * longint'(dir_z_q) + 32768;
    np = longint'(prefix_q) + (dot >>> 16);
    if (np > 64'sh7FFF_FFFF) np = 64'sh7FFF_FFFF;
    if (np < -64'sh8000_0000) np = -64'sh8000_0000;
    k = int'(bond_pos_q) + 1;
    np_mag = magnitude(np);
    psq = np_mag * np_mag;
    a_term = 128'(k) * 128'(psq) + 128'(prefix_sq_sum_q);
    b_term = (128'(np_mag) * 128'(magnitude(prefix_sum_q))) << 1;
    if (((np < 0) != (prefix_sum_q < 0)) && np != 0 && prefix_sum_q != 0) begin
      inc = a_term + b_term;
    end else begin
      inc = (a_term >= b_term) ? a_term - b_term : '0;
    end
    if (inc > 128'(TOTAL_MAX - total_q)) total_q = TOTAL_MAX;
    else total_q = total_q + inc[TOTAL_W-1:0];
    prefix_q = np[NP_W-1:0];
    prefix_sum_q = prefix_sum_q + np[S1_W-1:0];
    prefix_sq_sum_q = (psq > ~prefix_sq_sum_q) ? '1 : prefix_sq_sum_q + psq;
    bond_pos_q = k[POS_W-1:0];
    eff_len = len_q;
    if (eff_len < LEN_MIN) eff_len = LEN_MIN;
    if (eff_len > LEN_MAX) eff_len = LEN_MAX;
    closes_chain = (k >= eff_len - 1);
    if (closes_chain) begin
      if (count_q != COUNT_MAX) count_q = count_q + 1'b1;
      prefix_q = '0;
      prefix_sum_q = '0;
      prefix_sq_sum_q = '0;
      bond_pos_q = '0;
    end
    r.total_sum = total_q;
    r.chains_done = count_q;
    r.chain_end = closes_chain;
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] random_director();
    int v;
    case ($urandom_range(7))
      0: v = -65536;
      1: v = 65536;
      2: v = 0;
      default: v = int'($urandom_range(131072)) - 65536;
    endcase
    return CFG_W'(v);
  endfunction

  function automatic logic signed [BOND_W-1:0] random_component();
    logic signed [BOND_W-1:0] raw;
    raw = BOND_W'($urandom);
    return raw >>> (BOND_W - $urandom_range(BOND_W, 1));
  endfunction

  function automatic logic signed [BOND_W-1:0] near_full_scale(input bit flip);
    logic signed [BOND_W-1:0] v;
    v = BOND_HI - BOND_W'($urandom_range(4095));
    return flip ? -v : v;
  endfunction

  task automatic send_bond(input logic signed [BOND_W-1:0] bx,
                           input logic signed [BOND_W-1:0] by,
                           input logic signed [BOND_W-1:0] bz);
    while ($urandom_range(99) < tx_idle_pct) begin
      bond_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    bond_ch.valid  <= 1'b1;
    bond_ch.bond_x <= bx;
    bond_ch.bond_y <= by;
    bond_ch.bond_z <= bz;
    @(posedge clk_i);
    while (!bond_ch.ready) @(posedge clk_i);
    predicted_results.push_back(accumulate_bond(bx, by, bz));
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    bond_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_CHAIN_LENGTH: len_q = value[LEN_W-1:0];
      CFG_DIR_X: dir_x_q = value;
      CFG_DIR_Y: dir_y_q = value;
      CFG_DIR_Z: dir_z_q = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_directed_cases();
    send_bond(0, 0, BOND_HI);
    send_bond(0, 0, BOND_LO);
    send_bond(BOND_HI, BOND_LO, 0);
    // Half-way projections round toward positive infinity.
    write_register(CFG_DIR_X, DIR_HALF);
    write_register(CFG_DIR_Y, '0);
    write_register(CFG_DIR_Z, '0);
    send_bond(1, 0, 0);
    send_bond(-1, 0, 0);
    send_bond(-3, 0, 0);
    write_register(CFG_DIR_X, DIR_NEG_ONE);
    write_register(CFG_DIR_Y, DIR_ONE);
    write_register(CFG_DIR_Z, DIR_NEG_ONE);
    send_bond(BOND_LO, BOND_HI, BOND_LO);
    send_bond(BOND_HI, BOND_LO, BOND_HI);
    // Lengths below the minimum act as the minimum.
    write_register(CFG_CHAIN_LENGTH, '0);
    send_bond(BOND_HI, BOND_HI, BOND_HI);
    write_register(CFG_CHAIN_LENGTH, CFG_W'(1));
    send_bond(BOND_LO, BOND_LO, BOND_LO);
    // The second bond flips the prefix sign against the earlier prefix sum.
    write_register(CFG_CHAIN_LENGTH, CFG_W'(4));
    send_bond(BOND_HI, 0, 0);
    send_bond(BOND_LO, 0, 0);
    send_bond(0, 0, 0);
    // An oversized length acts as the maximum; shortening it mid-chain ends the chain.
    write_register(CFG_CHAIN_LENGTH, CFG_W'(2047));
    repeat (4) send_bond(random_component(), random_component(), random_component());
    write_register(CFG_CHAIN_LENGTH, CFG_W'(3));
    send_bond(0, 0, BOND_HI);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_bonds);
    int unsigned len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_bonds; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(15))
          0: len = $urandom_range(1);
          1: len = $urandom_range(2047, 1025);
          2: len = $urandom_range(64, 13);
          default: len = $urandom_range(12, 2);
        endcase
        write_register(CFG_CHAIN_LENGTH, CFG_W'(len));
        write_register(CFG_DIR_X, random_director());
        write_register(CFG_DIR_Y, random_director());
        write_register(CFG_DIR_Z, random_director());
      end
      send_bond(random_component(), random_component(), random_component());
    end
  endtask

  // One chain at the largest length with a steadily growing prefix, which drives
  // the square sum and the total into saturation.
  task automatic test_full_length_chain();
    bit flip_x;
    bit flip_y;
    bit flip_z;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    flip_x = $urandom_range(1);
    flip_y = $urandom_range(1);
    flip_z = $urandom_range(1);
    write_register(CFG_CHAIN_LENGTH, CFG_W'(LEN_MIN));
    send_bond(0, 0, 0);
    write_register(CFG_CHAIN_LENGTH, CFG_W'(LEN_MAX));
    write_register(CFG_DIR_X, flip_x ? DIR_NEG_ONE : DIR_ONE);
    write_register(CFG_DIR_Y, flip_y ? DIR_NEG_ONE : DIR_ONE);
    write_register(CFG_DIR_Z, flip_z ? DIR_NEG_ONE : DIR_ONE);
    repeat (MAX_CHAIN_LEN - 1) begin
      send_bond(near_full_scale(flip_x), near_full_scale(flip_y), near_full_scale(flip_z));
    end
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    chain_result_t got;
    chain_result_t want;
    got = {result_ch.total_sum, result_ch.chains_done, result_ch.chain_end};
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result transfer: total %0d chains %0d end %0b",
                   got.total_sum, got.chains_done, got.chain_end);
        end
      end else begin
        want = predicted_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Result mismatch: expected total %0d chains %0d end %0b, got %0d %0d %0b",
                     want.total_sum, want.chains_done, want.chain_end,
                     got.total_sum, got.chains_done, got.chain_end);
          end
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_CHAIN_LENGTH;
    cfg_wdata = '0;
    bond_ch.valid = 1'b0;
    bond_ch.bond_x = '0;
    bond_ch.bond_y = '0;
    bond_ch.bond_z = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_traffic(11, 60, 130);
    test_random_traffic(60, 11, 130);
    test_random_traffic(0, 0, 130);
    test_full_length_chain();
    wait_for_results();
    repeat (24) @(negedge clk_i);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pscsa_pkg.sv
sv/pscsa_ifs.sv
sv/pscsa_ctrl.sv
sv/pscsa_datapath.sv
sv/projected_subchain_size_accumulator_unit.sv
verif/projected_subchain_size_accumulator_unit_test.sv
